FILE: rtl/bfa_pkg.sv
// Package with the request op codes and response status codes of the frame allocator.
package bfa_pkg;

   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_ALLOC     = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE      = 2'd1;
   localparam logic [OP_W-1:0] OP_MARK_USED = 2'd2;
   localparam logic [OP_W-1:0] OP_MARK_FREE = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

endpackage

FILE: rtl/bfa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module bfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bfa_find.sv
// Lowest-free-bit search over one map word, limited to frames below the frame count.
module bfa_find #(
   parameter int WORD_BITS = 32,
   parameter int ADDR_W    = 7,
   parameter int CNT_W     = 13
) (
   input  logic [WORD_BITS-1:0]         word,
   input  logic [ADDR_W-1:0]            addr,
   input  logic [CNT_W-1:0]             lim,
   output logic                         found,
   output logic [$clog2(WORD_BITS)-1:0] bit_idx,
   output logic                         last
);

   localparam int WB_W   = $clog2(WORD_BITS);
   localparam int BASE_W = ADDR_W + WB_W;
   localparam int CMP_W  = (BASE_W > CNT_W ? BASE_W : CNT_W) + 1;

   logic [CMP_W-1:0]     base;
   logic [CMP_W-1:0]     lim_x;
   logic [CMP_W-1:0]     rem;
   logic                 any_in_range;
   logic                 full;
   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] free_vec;

   always_comb begin
      base         = CMP_W'({addr, {WB_W{1'b0}}});
      lim_x        = CMP_W'(lim);
      any_in_range = lim_x > base;
      rem          = lim_x - base;
      full         = rem >= CMP_W'(WORD_BITS);
      last         = lim_x <= (base + CMP_W'(WORD_BITS));
      for (int i = 0; i < WORD_BITS; i++) begin
         mask[i] = any_in_range && (full || (CMP_W'(i) < rem));
      end
      free_vec = ~word & mask;
      found    = |free_vec;
      bit_idx  = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            bit_idx = WB_W'(i);
         end
      end
   end

endmodule

FILE: rtl/bitmap_frame_allocator_core.sv
// Top level of the first-fit bitmap frame allocator with its control sequencer.
// A rejected request (no free frame or index out of range) never touches the map.
// Any other request passes through the read state, which updates the map bit, sends the
// response, then rescans one map word per cycle through the single RAM read port.
// After reset a fill pass writes every map word to all ones.
// After the fill a register write starts the rescan; no request is taken until it ends.
module bitmap_frame_allocator_core #(
   parameter int MAX_FRAMES    = 4096,
   parameter int MAP_WORD_BITS = 32   // a power of two
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // Fields from bit 0: op, frame_index, zero padding.
   input  logic [((2 + $clog2(MAX_FRAMES) + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // Fields from bit 0: result_index, status, free_frames, zero padding.
   output logic [((2 + $clog2(MAX_FRAMES) + $clog2(MAX_FRAMES + 1) + 7) / 8) * 8 - 1:0]
                                                    rsp_tdata,
   input  logic                                     csr_wr_en,
   input  logic [$clog2(MAX_FRAMES + 1)-1:0]        csr_wr_data
);

   import bfa_pkg::*;

   localparam int IDX_W     = $clog2(MAX_FRAMES);
   localparam int CNT_W     = $clog2(MAX_FRAMES + 1);
   localparam int WB_W      = $clog2(MAP_WORD_BITS);
   localparam int MAP_WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WA_W      = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
   localparam int RSP_USED  = IDX_W + STATUS_W + CNT_W;
   localparam int RSP_W     = ((RSP_USED + 7) / 8) * 8;

   localparam logic [WA_W-1:0]  LAST_WORD = WA_W'(MAP_WORDS - 1);
   localparam logic [CNT_W-1:0] FRAMES_MAX = CNT_W'(MAX_FRAMES);

   localparam logic [1:0] S_FILL = 2'd0;
   localparam logic [1:0] S_IDLE = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_SCAN = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [WA_W-1:0]          fill_addr_ff, fill_addr_in;
   logic [CNT_W-1:0]         frames_ff, frames_in;
   logic                     rescan_ff, rescan_in;
   logic [CNT_W-1:0]         free_count_ff, free_count_in;
   logic [IDX_W-1:0]         lowest_free_ff, lowest_free_in;
   logic                     any_free_ff, any_free_in;
   logic [IDX_W-1:0]         tgt_idx_ff, tgt_idx_in;
   logic                     tgt_used_ff, tgt_used_in;
   logic [WA_W-1:0]          scan_addr_ff, scan_addr_in;
   logic [WA_W-1:0]          eval_addr_ff, eval_addr_in;
   logic                     scan_pend_ff, scan_pend_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]         rsp_idx_ff, rsp_idx_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;

   logic [CNT_W-1:0]         lim;
   logic [OP_W-1:0]          req_op;
   logic [IDX_W-1:0]         req_idx;
   logic                     req_accept;
   logic                     out_free;
   logic                     ram_we;
   logic [WA_W-1:0]          ram_waddr;
   logic [MAP_WORD_BITS-1:0] ram_wdata;
   logic [WA_W-1:0]          ram_raddr;
   logic [MAP_WORD_BITS-1:0] ram_rdata;
   logic                     find_found;
   logic [WB_W-1:0]          find_bit;
   logic                     find_last;
   logic [WB_W-1:0]          tgt_bit;
   logic                     old_bit;
   logic                     flip;

   assign lim      = (frames_ff > FRAMES_MAX) ? FRAMES_MAX : frames_ff;
   assign req_op   = req_tdata[OP_W-1:0];
   assign req_idx  = req_tdata[OP_W +: IDX_W];
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && !rescan_ff && !csr_wr_en && out_free;
   assign req_accept = req_tvalid && req_tready;
   assign tgt_bit  = WB_W'(tgt_idx_ff);
   assign old_bit  = ram_rdata[tgt_bit];
   assign flip     = (state_ff == S_READ) && (old_bit != tgt_used_ff);

   bfa_ram #(
      .WIDTH(MAP_WORD_BITS),
      .DEPTH(MAP_WORDS)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   bfa_find #(
      .WORD_BITS(MAP_WORD_BITS),
      .ADDR_W   (WA_W),
      .CNT_W    (CNT_W)
   ) u_find (
      .word   (ram_rdata),
      .addr   (eval_addr_ff),
      .lim    (lim),
      .found  (find_found),
      .bit_idx(find_bit),
      .last   (find_last)
   );

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = fill_addr_ff;
      ram_wdata = '1;
      ram_raddr = scan_addr_ff;
      if (state_ff == S_FILL) begin
         ram_we = 1'b1;
      end else if (flip) begin
         ram_we    = 1'b1;
         ram_waddr = WA_W'(tgt_idx_ff >> WB_W);
         ram_wdata = ram_rdata;
         ram_wdata[tgt_bit] = tgt_used_ff;
      end
      if (state_ff == S_IDLE) begin
         ram_raddr = (req_op == OP_ALLOC) ? WA_W'(lowest_free_ff >> WB_W)
                                          : WA_W'(req_idx >> WB_W);
      end
   end

   always_comb begin
      state_in       = state_ff;
      fill_addr_in   = fill_addr_ff;
      frames_in      = csr_wr_en ? csr_wr_data : frames_ff;
      rescan_in      = rescan_ff || (csr_wr_en && state_ff != S_FILL);
      free_count_in  = free_count_ff;
      lowest_free_in = lowest_free_ff;
      any_free_in    = any_free_ff;
      tgt_idx_in     = tgt_idx_ff;
      tgt_used_in    = tgt_used_ff;
      scan_addr_in   = scan_addr_ff;
      eval_addr_in   = eval_addr_ff;
      scan_pend_in   = scan_pend_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_idx_in     = rsp_idx_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;

      unique case (state_ff)
         S_FILL: begin
            fill_addr_in = fill_addr_ff + 1'b1;
            if (fill_addr_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (rescan_ff) begin
               state_in     = S_SCAN;
               rescan_in    = csr_wr_en;
               scan_addr_in = '0;
               scan_pend_in = 1'b0;
            end else if (req_accept) begin
               if (req_op == OP_ALLOC) begin
                  if (!any_free_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_idx_in    = '0;
                     rsp_status_in = STATUS_NOFREE;
                     rsp_count_in  = free_count_ff;
                  end else begin
                     tgt_idx_in  = lowest_free_ff;
                     tgt_used_in = 1'b1;
                     state_in    = S_READ;
                  end
               end else if (CNT_W'(req_idx) >= lim) begin
                  rsp_valid_in  = 1'b1;
                  rsp_idx_in    = req_idx;
                  rsp_status_in = STATUS_RANGE;
                  rsp_count_in  = free_count_ff;
               end else begin
                  tgt_idx_in  = req_idx;
                  tgt_used_in = (req_op == OP_MARK_USED);
                  state_in    = S_READ;
               end
            end
         end
         S_READ: begin
            if (flip) begin
               if (tgt_used_ff) begin
                  if (free_count_ff != '0) begin
                     free_count_in = free_count_ff - 1'b1;
                  end
               end else begin
                  free_count_in = free_count_ff + 1'b1;
               end
            end
            rsp_valid_in  = 1'b1;
            rsp_idx_in    = tgt_idx_ff;
            rsp_status_in = STATUS_OK;
            rsp_count_in  = free_count_in;
            state_in      = S_SCAN;
            rescan_in     = 1'b0;
            scan_addr_in  = '0;
            scan_pend_in  = 1'b0;
         end
         S_SCAN: begin
            rescan_in    = 1'b0;
            scan_pend_in = 1'b1;
            eval_addr_in = scan_addr_ff;
            if (scan_addr_ff != LAST_WORD) begin
               scan_addr_in = scan_addr_ff + 1'b1;
            end
            if (csr_wr_en) begin
               scan_addr_in = '0;
               scan_pend_in = 1'b0;
            end else if (scan_pend_ff) begin
               if (find_found) begin
                  any_free_in    = 1'b1;
                  lowest_free_in = IDX_W'({eval_addr_ff, find_bit});
                  state_in       = S_IDLE;
               end else if (find_last || eval_addr_ff == LAST_WORD) begin
                  any_free_in    = 1'b0;
                  lowest_free_in = '0;
                  state_in       = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_FILL;
         fill_addr_ff   <= '0;
         frames_ff      <= FRAMES_MAX;
         rescan_ff      <= 1'b0;
         free_count_ff  <= '0;
         lowest_free_ff <= '0;
         any_free_ff    <= 1'b0;
         scan_addr_ff   <= '0;
         eval_addr_ff   <= '0;
         scan_pend_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fill_addr_ff   <= fill_addr_in;
         frames_ff      <= frames_in;
         rescan_ff      <= rescan_in;
         free_count_ff  <= free_count_in;
         lowest_free_ff <= lowest_free_in;
         any_free_ff    <= any_free_in;
         scan_addr_ff   <= scan_addr_in;
         eval_addr_ff   <= eval_addr_in;
         scan_pend_ff   <= scan_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_idx_ff    <= tgt_idx_in;
      tgt_used_ff   <= tgt_used_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_count_ff, rsp_status_ff, rsp_idx_ff});

   a_read_then_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |=> state_ff == S_SCAN)
      else $error("Map update was not followed by a rescan.");

   a_lowest_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !rescan_ff && any_free_ff) |-> CNT_W'(lowest_free_ff) < lim)
      else $error("Lowest free frame lies outside the frame range.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= FRAMES_MAX)
      else $error("Free frame count exceeds the number of frames.");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |=> (free_count_ff == $past(free_count_ff)
                              || free_count_ff == $past(free_count_ff) + 1'b1
                              || free_count_ff == $past(free_count_ff) - 1'b1))
      else $error("Free frame count moved by more than one.");

endmodule
